[rtl/core/bsov_pkg.sv]
`default_nettype none
package bsov_pkg;
  localparam int MaxBoxes = 4096;
  localparam int CoordBits = 18;
  localparam int IdxBits = 12;
  localparam int CntBits = 13;
  localparam int VolBits = 55;
  localparam int ClipBits = 17;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t x_lo;
    coord_t y_lo;
    coord_t z_lo;
    coord_t x_hi;
    coord_t y_hi;
    coord_t z_hi;
  } box_t;

  typedef struct packed {
    logic turn_on;
    box_t b;
  } rule_t;

  typedef struct packed {
    logic [VolBits-1:0] lit_cells;
    logic [CntBits-1:0] box_count;
    logic               skipped;
    logic               overflow;
  } res_t;

  // extent along one axis, one more than the span
  function automatic logic [CoordBits:0] extent(coord_t lo, coord_t hi);
    logic signed [CoordBits+1:0] d;
    d = {{2{hi[CoordBits-1]}}, hi} - {{2{lo[CoordBits-1]}}, lo} + (CoordBits+2)'(1);
    return d[CoordBits:0];
  endfunction
endpackage
`default_nettype wire

[rtl/core/bsov_if.sv]
`default_nettype none
interface bsov_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/bsov_split.sv]
`default_nettype none
// one cut of a piece at a plane; returns lower and upper parts
module bsov_split (
  input  wire bsov_pkg::box_t p,
  input  wire logic [1:0]     ax,
  input  wire bsov_pkg::coord_t h,
  input  wire logic           h_ovf,
  output bsov_pkg::box_t      lo_part,
  output bsov_pkg::box_t      hi_part,
  output logic                cut
);
  bsov_pkg::coord_t plo, phi;
  always_comb begin
    case (ax)
      2'd0: begin plo = p.x_lo; phi = p.x_hi; end
      2'd1: begin plo = p.y_lo; phi = p.y_hi; end
      default: begin plo = p.z_lo; phi = p.z_hi; end
    endcase
    cut = !h_ovf && (plo < h) && (h <= phi);
    lo_part = p;
    hi_part = p;
    case (ax)
      2'd0: begin lo_part.x_hi = h - 1'b1; hi_part.x_lo = h; end
      2'd1: begin lo_part.y_hi = h - 1'b1; hi_part.y_lo = h; end
      default: begin lo_part.z_hi = h - 1'b1; hi_part.z_lo = h; end
    endcase
  end
endmodule
`default_nettype wire

[rtl/core/box_set_on_off_volume_unit.sv]
`default_nettype none
// per request: each stored box is read and checked against the rule; one that meets
// the rule gets six cuts, then the piece walk; then the kept table is copied back and
// its volumes summed
// a skipped rule goes straight to the volume sum over the stored table; one request at a
// time, the next is taken from the cycle after the result is accepted
// reset is synchronous, active low: empties the table, clip radius to max
module box_set_on_off_volume_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  bsov_if.sink      in_ch,
  bsov_if.source    out_ch,
  bsov_if.sink      cfg_ch
);
  localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_RD = 4'd2, S_RDW = 4'd3,
    S_MEET = 4'd4, S_CUT = 4'd5, S_EMIT = 4'd6, S_APP = 4'd7, S_CPRD = 4'd8,
    S_CPW = 4'd9, S_MUL1 = 4'd10, S_MUL2 = 4'd11, S_OUT = 4'd12;
  localparam bsov_pkg::coord_t CoordMax = {1'b0, {(bsov_pkg::CoordBits-1){1'b1}}};

  logic [3:0] st_r, st_nxt;
  logic [bsov_pkg::ClipBits-1:0] clip_r;
  bsov_pkg::rule_t rule_r;
  logic [bsov_pkg::CntBits-1:0] cnt_r, n_r, i_r;
  logic skip_r, ovf_r;
  logic [bsov_pkg::VolBits-1:0] sum_r;
  bsov_pkg::box_t cur_r, rd_tab_r, rd_scr_r;
  bsov_pkg::box_t tab_mem [bsov_pkg::MaxBoxes];
  bsov_pkg::box_t scr_mem [bsov_pkg::MaxBoxes];
  bsov_pkg::box_t pc_r [27];
  logic [4:0] pn_r, pi_r, tn_r;
  bsov_pkg::box_t tp_r [27];
  logic [2:0] plane_r;
  logic [2*bsov_pkg::CoordBits+1:0] m1_r;
  bsov_pkg::res_t res_r;
  logic out_v_r;

  assign in_ch.ready = (st_r == S_IDLE) && !out_v_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_v_r;
  assign out_ch.data = res_r;

  // plane selection: x_lo, x_hi+1, y_lo, y_hi+1, z_lo, z_hi+1
  bsov_pkg::coord_t h;
  logic h_ovf;
  logic [1:0] ax;
  always_comb begin
    ax = plane_r[2:1];
    h_ovf = 1'b0;
    case (plane_r)
      3'd0: h = rule_r.b.x_lo;
      3'd1: begin h = rule_r.b.x_hi + 1'b1; h_ovf = (rule_r.b.x_hi == CoordMax); end
      3'd2: h = rule_r.b.y_lo;
      3'd3: begin h = rule_r.b.y_hi + 1'b1; h_ovf = (rule_r.b.y_hi == CoordMax); end
      3'd4: h = rule_r.b.z_lo;
      default: begin h = rule_r.b.z_hi + 1'b1; h_ovf = (rule_r.b.z_hi == CoordMax); end
    endcase
  end

  bsov_pkg::box_t s_lo, s_hi;
  logic s_cut;
  bsov_split u_split (.p(pc_r[pi_r]), .ax(ax), .h(h), .h_ovf(h_ovf),
    .lo_part(s_lo), .hi_part(s_hi), .cut(s_cut));

  // relations between current piece and rule
  bsov_pkg::box_t rb, ep;
  logic meet, within_rule;
  assign rb = rule_r.b;
  assign ep = pc_r[pi_r];
  always_comb begin
    meet = !(cur_r.x_lo > rb.x_hi || cur_r.x_hi < rb.x_lo ||
             cur_r.y_lo > rb.y_hi || cur_r.y_hi < rb.y_lo ||
             cur_r.z_lo > rb.z_hi || cur_r.z_hi < rb.z_lo);
    within_rule = !(ep.x_lo < rb.x_lo || ep.x_hi > rb.x_hi ||
                    ep.y_lo < rb.y_lo || ep.y_hi > rb.y_hi ||
                    ep.z_lo < rb.z_lo || ep.z_hi > rb.z_hi);
  end

  bsov_pkg::rule_t rin;
  logic [bsov_pkg::CoordBits-1:0] mag;
  logic bad;
  assign rin = in_ch.data;
  always_comb begin
    mag = rin.b.x_lo[bsov_pkg::CoordBits-1] ? -rin.b.x_lo : rin.b.x_lo;
    bad = (rin.b.x_lo > rin.b.x_hi) || (rin.b.y_lo > rin.b.y_hi) ||
          (rin.b.z_lo > rin.b.z_hi) ||
          (mag > {{(bsov_pkg::CoordBits-bsov_pkg::ClipBits){1'b0}}, clip_r});
  end

  logic [bsov_pkg::IdxBits-1:0] i_idx, n_idx;
  assign i_idx = i_r[bsov_pkg::IdxBits-1:0];
  assign n_idx = n_r[bsov_pkg::IdxBits-1:0];
  logic full;
  assign full = n_r[bsov_pkg::CntBits-1];

  // new table taken over on the first copy pass; count the result reports
  logic commit;
  logic [bsov_pkg::CntBits-1:0] lim;
  assign commit = !skip_r && !ovf_r && (i_r == '0);
  assign lim = commit ? n_r : cnt_r;

  // volume of the current box from the registered x by y product
  logic [bsov_pkg::CoordBits:0] ez;
  logic [3*bsov_pkg::CoordBits+2:0] vol;
  assign ez = bsov_pkg::extent(cur_r.z_lo, cur_r.z_hi);
  assign vol = {{(bsov_pkg::CoordBits+1){1'b0}}, m1_r} *
               {{(2*bsov_pkg::CoordBits+2){1'b0}}, ez};

  // memory ports
  logic scr_we, tab_we;
  bsov_pkg::box_t scr_wd;
  always_ff @(posedge clk) begin
    rd_tab_r <= tab_mem[i_idx];
    rd_scr_r <= scr_mem[i_idx];
    if (scr_we) scr_mem[n_idx] <= scr_wd;
    if (tab_we) tab_mem[i_idx] <= rd_scr_r;
  end

  always_comb begin
    scr_we = 1'b0;
    scr_wd = cur_r;
    tab_we = 1'b0;
    case (st_r)
      S_MEET: scr_we = !meet && !full;
      S_EMIT: begin scr_wd = ep; scr_we = (pi_r < pn_r) && !within_rule && !full; end
      S_APP: begin scr_wd = rb; scr_we = rule_r.turn_on && !full; end
      S_CPW: tab_we = !ovf_r && !skip_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      clip_r <= '1;
      cnt_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) clip_r <= cfg_ch.data[bsov_pkg::ClipBits-1:0];
      if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          rule_r <= rin;
          skip_r <= bad;
          ovf_r <= 1'b0;
          n_r <= '0;
          i_r <= '0;
          st_r <= bad ? S_CPRD : S_CHK;
        end
        S_CHK: st_r <= (i_r < cnt_r) ? S_RD : S_APP;
        S_RD: st_r <= S_RDW;
        S_RDW: begin cur_r <= rd_tab_r; st_r <= S_MEET; end
        S_MEET: if (!meet) begin
          if (full) begin ovf_r <= 1'b1; st_r <= S_CPRD; i_r <= '0; end
          else begin n_r <= n_r + 1'b1; i_r <= i_r + 1'b1; st_r <= S_CHK; end
        end else begin
          pc_r[0] <= cur_r; pn_r <= 5'd1; pi_r <= '0; tn_r <= '0; plane_r <= '0;
          st_r <= S_CUT;
        end
        // one piece cut per cycle into the temporary list
        S_CUT: if (pi_r < pn_r && tn_r < 5'd26) begin
          if (s_cut) begin
            tp_r[tn_r] <= s_lo; tp_r[tn_r+5'd1] <= s_hi; tn_r <= tn_r + 5'd2;
          end else begin
            tp_r[tn_r] <= pc_r[pi_r]; tn_r <= tn_r + 5'd1;
          end
          pi_r <= pi_r + 1'b1;
        end else begin
          for (int k = 0; k < 27; k++) pc_r[k] <= tp_r[k];
          pn_r <= tn_r; tn_r <= '0; pi_r <= '0;
          if (plane_r == 3'd5) st_r <= S_EMIT;
          else plane_r <= plane_r + 1'b1;
        end
        S_EMIT: if (pi_r < pn_r) begin
          if (!within_rule) begin
            if (full) begin ovf_r <= 1'b1; st_r <= S_CPRD; i_r <= '0; end
            else n_r <= n_r + 1'b1;
          end
          pi_r <= pi_r + 1'b1;
        end else begin i_r <= i_r + 1'b1; st_r <= S_CHK; end
        S_APP: begin
          if (rule_r.turn_on) begin
            if (full) ovf_r <= 1'b1; else n_r <= n_r + 1'b1;
          end
          i_r <= '0; st_r <= S_CPRD; sum_r <= '0;
        end
        // copy back and sum volumes
        S_CPRD: begin
          if (commit) cnt_r <= n_r;
          if (i_r == '0) sum_r <= '0;
          if (i_r < lim) st_r <= S_CPW;
          else begin
            res_r <= '{(i_r == '0) ? {bsov_pkg::VolBits{1'b0}} : sum_r, lim,
                       skip_r, ovf_r};
            out_v_r <= 1'b1; st_r <= S_OUT;
          end
        end
        S_CPW: begin
          cur_r <= ovf_r || skip_r ? rd_tab_r : rd_scr_r;
          st_r <= S_MUL1;
        end
        S_MUL1: begin
          m1_r <= bsov_pkg::extent(cur_r.x_lo, cur_r.x_hi) *
                  bsov_pkg::extent(cur_r.y_lo, cur_r.y_hi);
          st_r <= S_MUL2;
        end
        S_MUL2: begin
          sum_r <= sum_r + vol[bsov_pkg::VolBits-1:0];
          i_r <= i_r + 1'b1; st_r <= S_CPRD;
        end
        S_OUT: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[bench/lit_table_checker.sv]
module lit_table_checker (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 rule_valid,
  input  wire logic                 rule_ready,
  input  wire logic [$bits(bsov_pkg::rule_t)-1:0] rule_data,
  input  wire logic                 res_valid,
  input  wire logic                 res_ready,
  input  wire logic [$bits(bsov_pkg::res_t)-1:0]  res_data,
  input  wire logic                 clip_valid,
  input  wire logic                 clip_ready,
  input  wire logic [bsov_pkg::ClipBits-1:0]  clip_data,
  output int                        fail_count,
  output int                        pending_count
);

  typedef struct {
    int lo[3];
    int hi[3];
  } cube_t;

  cube_t                         lit_boxes[bsov_pkg::MaxBoxes];
  cube_t                         new_boxes[bsov_pkg::MaxBoxes];
  int                            lit_box_count;
  logic [bsov_pkg::ClipBits-1:0] clip_radius;
  bsov_pkg::res_t                expected_results[$];

  function automatic cube_t to_cube(bsov_pkg::box_t b);
    cube_t c;
    c.lo[0] = b.x_lo; c.lo[1] = b.y_lo; c.lo[2] = b.z_lo;
    c.hi[0] = b.x_hi; c.hi[1] = b.y_hi; c.hi[2] = b.z_hi;
    return c;
  endfunction

  function automatic bit cubes_meet(cube_t a, cube_t b);
    for (int k = 0; k < 3; k++)
      if (a.lo[k] > b.hi[k] || a.hi[k] < b.lo[k]) return 0;
    return 1;
  endfunction

  function automatic bit cube_within(cube_t a, cube_t b);
    for (int k = 0; k < 3; k++)
      if (a.lo[k] < b.lo[k] || a.hi[k] > b.hi[k]) return 0;
    return 1;
  endfunction

  function automatic longint unsigned cube_volume(cube_t c);
    longint unsigned v;
    v = 1;
    for (int k = 0; k < 3; k++) v *= longint'(c.hi[k]) - longint'(c.lo[k]) + 1;
    return v;
  endfunction

  // split each piece at plane h on one axis, stopping once the list holds 26 or more
  function automatic int split_pieces(ref cube_t p[27], input int n, input int ax,
                                      input int h);
    cube_t tmp[27];
    int    m;
    m = 0;
    for (int i = 0; i < n && m < 26; i++) begin
      if (p[i].lo[ax] < h && h <= p[i].hi[ax]) begin
        tmp[m] = p[i];
        tmp[m].hi[ax] = h - 1;
        m++;
        tmp[m] = p[i];
        tmp[m].lo[ax] = h;
        m++;
      end else begin
        tmp[m] = p[i];
        m++;
      end
    end
    for (int i = 0; i < m; i++) p[i] = tmp[i];
    return m;
  endfunction

  // run one rule over the lit table and return the result it gives
  function automatic bsov_pkg::res_t predict_rule(bsov_pkg::rule_t rule);
    bsov_pkg::res_t  r;
    cube_t           rc;
    cube_t           p[27];
    int              n, cnt, mag;
    bit              skip, ovf;
    longint unsigned total;
    rc = to_cube(rule.b);
    skip = 0;
    ovf = 0;
    n = 0;
    for (int k = 0; k < 3; k++) if (rc.lo[k] > rc.hi[k]) skip = 1;
    mag = rc.lo[0] < 0 ? -rc.lo[0] : rc.lo[0];
    if (mag > int'(clip_radius)) skip = 1;
    if (!skip) begin
      for (int i = 0; i < lit_box_count && !ovf; i++) begin
        if (!cubes_meet(lit_boxes[i], rc)) begin
          if (n >= bsov_pkg::MaxBoxes) begin
            ovf = 1;
            break;
          end
          new_boxes[n] = lit_boxes[i];
          n++;
        end else begin
          p[0] = lit_boxes[i];
          cnt = 1;
          for (int k = 0; k < 3; k++) begin
            cnt = split_pieces(p, cnt, k, rc.lo[k]);
            cnt = split_pieces(p, cnt, k, rc.hi[k] + 1);
          end
          for (int j = 0; j < cnt; j++) begin
            if (cube_within(p[j], rc)) continue;
            if (n >= bsov_pkg::MaxBoxes) begin
              ovf = 1;
              break;
            end
            new_boxes[n] = p[j];
            n++;
          end
        end
      end
      if (!ovf && rule.turn_on) begin
        if (n >= bsov_pkg::MaxBoxes) ovf = 1;
        else begin
          new_boxes[n] = rc;
          n++;
        end
      end
      if (!ovf) begin
        for (int i = 0; i < n; i++) lit_boxes[i] = new_boxes[i];
        lit_box_count = n;
      end
    end
    total = 0;
    for (int i = 0; i < lit_box_count; i++) total += cube_volume(lit_boxes[i]);
    r.lit_cells = total[bsov_pkg::VolBits-1:0];
    r.box_count = lit_box_count[bsov_pkg::CntBits-1:0];
    r.skipped = skip;
    r.overflow = ovf;
    return r;
  endfunction

  // watch the channels, predict and compare
  always @(posedge clk) begin
    bsov_pkg::res_t got, want;
    if (!rst_n) begin
      lit_box_count = 0;
      clip_radius = '1;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (rule_valid && rule_ready)
        expected_results = {expected_results,
                            predict_rule(bsov_pkg::rule_t'(rule_data))};
      if (clip_valid && clip_ready) clip_radius = clip_data;
      if (res_valid && res_ready) begin
        got = bsov_pkg::res_t'(res_data);
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: %p", got);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.lit_cells !== want.lit_cells) begin
            $error("lit_cells: expected %0d, got %0d", want.lit_cells, got.lit_cells);
            fail_count++;
          end
          if (got.box_count !== want.box_count) begin
            $error("box_count: expected %0d, got %0d", want.box_count, got.box_count);
            fail_count++;
          end
          if (got.skipped !== want.skipped) begin
            $error("skipped: expected %0b, got %0b", want.skipped, got.skipped);
            fail_count++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
            fail_count++;
          end
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

[bench/tb.sv]
module tb;

  localparam int CycleLimit = 100000000;

  logic clk;
  logic rst_n;
  int   fail_count, pending_count, cycles, results_seen;
  bit   hold_done;

  bsov_if #(.W($bits(bsov_pkg::rule_t))) in_ch ();
  bsov_if #(.W($bits(bsov_pkg::res_t)))  out_ch ();
  bsov_if #(.W(bsov_pkg::ClipBits))      cfg_ch ();

  box_set_on_off_volume_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  lit_table_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rule_valid    (in_ch.valid),
    .rule_ready    (in_ch.ready),
    .rule_data     (in_ch.data),
    .res_valid     (out_ch.valid),
    .res_ready     (out_ch.ready),
    .res_data      (out_ch.data),
    .clip_valid    (cfg_ch.valid),
    .clip_ready    (cfg_ch.ready),
    .clip_data     (cfg_ch.data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // run time limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("[box_set_on_off_volume_unit] ERROR");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off so the block backs up
  initial begin
    int stall;
    out_ch.ready = 0;
    results_seen = 0;
    hold_done = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!hold_done && results_seen == 40) begin
        stall = 4000;
        hold_done = 1;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        out_ch.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (!out_ch.valid);
      results_seen++;
    end
  end

  task automatic send_rule(bsov_pkg::rule_t r, bit busy);
    int gap;
    gap = busy ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= r;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_clip(logic [bsov_pkg::ClipBits-1:0] v);
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
  endtask

  function automatic bsov_pkg::rule_t make_rule(bit on, int xl, int xh, int yl, int yh,
                                                int zl, int zh);
    bsov_pkg::rule_t r;
    r.turn_on = on;
    r.b.x_lo = xl; r.b.x_hi = xh;
    r.b.y_lo = yl; r.b.y_hi = yh;
    r.b.z_lo = zl; r.b.z_hi = zh;
    return r;
  endfunction

  // mostly small overlapping boxes, some full-range noise, some near the clip edge
  function automatic bsov_pkg::rule_t random_rule(int clip);
    bsov_pkg::rule_t r;
    int              pick, lo;
    pick = $urandom_range(0, 19);
    if (pick < 16) begin
      r.turn_on = $urandom_range(0, 2) != 0;
      lo = $urandom_range(0, 40) - 20; r.b.x_lo = lo; r.b.x_hi = lo + $urandom_range(0, 12);
      lo = $urandom_range(0, 40) - 20; r.b.y_lo = lo; r.b.y_hi = lo + $urandom_range(0, 12);
      lo = $urandom_range(0, 40) - 20; r.b.z_lo = lo; r.b.z_hi = lo + $urandom_range(0, 12);
    end else if (pick < 19) begin
      r = bsov_pkg::rule_t'({$urandom, $urandom, $urandom, $urandom});
    end else begin
      r = make_rule($urandom_range(0, 1), 0, 3, 0, 3, 0, 3);
      lo = clip + $urandom_range(0, 1);
      r.b.x_lo = $urandom_range(0, 1) ? lo : -lo;
      r.b.x_hi = 131071;
    end
    return r;
  endfunction

  // stimulus and verdict
  initial begin
    int   clip;
    bit   busy;
    in_ch.valid = 0;
    in_ch.data = '0;
    cfg_ch.valid = 0;
    cfg_ch.data = '0;
    rst_n = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty table, extremes, malformed, clip edge
    send_rule(make_rule(0, 0, 5, 0, 5, 0, 5), 0);
    send_rule(make_rule(1, 0, 9, 0, 9, 0, 9), 0);
    send_rule(make_rule(1, 5, 14, 5, 14, 5, 14), 0);
    send_rule(make_rule(0, 3, 7, 3, 7, 3, 7), 0);
    send_rule(make_rule(0, 2, 2, 2, 2, 2, 2), 1);
    send_rule(make_rule(1, 2, 1, 0, 3, 0, 3), 0);
    send_rule(make_rule(1, 0, 3, 4, 1, 0, 3), 0);
    send_rule(make_rule(1, 0, 3, 0, 3, 9, -9), 0);
    send_rule(make_rule(1, -131072, 131071, 0, 1, 0, 1), 0);
    send_rule(make_rule(1, -131071, 131071, -131072, 131071, -131072, 131071), 0);
    send_rule(make_rule(0, 131071, 131071, -131072, -131072, 131071, 131071), 0);
    send_rule(make_rule(0, -131071, 131071, -131072, 131071, -131072, 131071), 1);
    send_rule(make_rule(1, 131071, 131071, 131071, 131071, 131071, 131071), 0);
    send_rule(make_rule(0, 0, 20, 0, 20, 0, 20), 0);

    write_clip('0);
    send_rule(make_rule(1, 0, 4, 0, 4, 0, 4), 0);
    send_rule(make_rule(1, 1, 4, 0, 4, 0, 4), 0);
    send_rule(make_rule(1, -1, 4, 0, 4, 0, 4), 0);
    send_rule(make_rule(0, 0, 2, 1, 3, 1, 3), 0);

    write_clip('1);
    send_rule(make_rule(1, -131071, -131070, -5, 5, -5, 5), 0);
    send_rule(make_rule(0, -131071, 131071, -131072, 131071, -131072, 131071), 0);

    // random phases under several clip settings
    for (int ph = 0; ph < 4; ph++) begin
      clip = (ph == 0) ? 131071 : (ph == 3) ? 0 : $urandom_range(1, 25);
      write_clip(clip);
      for (int n = 0; n < 25; n++) begin
        busy = ($urandom_range(0, 3) == 0);
        send_rule(random_rule(clip), busy);
      end
    end
    in_ch.valid <= 0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("[box_set_on_off_volume_unit] OK");
    end else begin
      $display("[box_set_on_off_volume_unit] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/bsov_pkg.sv
rtl/core/bsov_if.sv
rtl/core/bsov_split.sv
rtl/core/box_set_on_off_volume_unit.sv
bench/lit_table_checker.sv
bench/tb.sv
